// File: sv/wsct_pkg.sv
// Shared constants and types of the weighted stratified cross-tabulation engine.
package wsct_pkg;

    // Default table depth
    localparam int MAX_CELLS_DEFAULT = 4096;

    // Field and register widths
    localparam int ACTION_W    = 2;
    localparam int LEVEL_W     = 8;
    localparam int STRATUM_W   = 5;
    localparam int WEIGHT_W    = 16;
    localparam int COUNT_W     = 31;
    localparam int STATUS_W    = 2;
    localparam int LEVEL_CFG_W = 9;
    localparam int STRAT_CFG_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 9;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef logic [ACTION_W-1:0]  action_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [COUNT_W-1:0]   count_t;

    // Action codes
    localparam action_t ACT_CLEAR = 2'd0;
    localparam action_t ACT_ACCUM = 2'd1;
    localparam action_t ACT_READ  = 2'd2;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_SAT   = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t REG_X_LEVELS  = 2'd0;
    localparam cfg_idx_t REG_Y_LEVELS  = 2'd1;
    localparam cfg_idx_t REG_STRATA    = 2'd2;
    localparam cfg_idx_t REG_WEIGHTED  = 2'd3;

    // Saturation value of a cell
    localparam count_t COUNT_MAX = 31'h7FFF_FFFF;

endpackage

// File: sv/wsct_if.sv
// Channel interfaces: request, response and configuration write.

interface wsct_req_if import wsct_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [LEVEL_W-1:0]   x_level;
    logic [LEVEL_W-1:0]   y_level;
    logic [STRATUM_W-1:0] stratum;
    logic [WEIGHT_W-1:0]  weight;

    modport source (output valid, action, x_level, y_level, stratum, weight, input ready);
    modport sink   (input valid, action, x_level, y_level, stratum, weight, output ready);
endinterface

interface wsct_rsp_if import wsct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, count, status, input ready);
    modport sink   (input valid, count, status, output ready);
endinterface

interface wsct_cfg_if import wsct_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

// File: sv/wsct_cell_mem.sv
// Cell count memory: one write port, one read port with registered data.
module wsct_cell_mem import wsct_pkg::*; #(
    parameter int DEPTH = MAX_CELLS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [COUNT_W-1:0]                   wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [COUNT_W-1:0]                   rdata
);

    logic [COUNT_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/weighted_stratified_cross_tabulation.sv
// Top level of the weighted stratified cross-tabulation engine.
//
// Keeps an x by y by stratum table of 31-bit cell counts in one memory.
// Channels: cfg writes one of four registers (x levels, y levels, strata,
// weighting); req carries one transaction (clear, accumulate or read);
// rsp returns one count and status for every request transaction.
// Accumulate and read run on a small sequencer around one shared 18x9
// multiplier: table size x*y, size check against MAX_CELLS, stratum offset,
// row offset, then a read of the memory and, for accumulate, a write-back.
// Clear sweeps the memory one cell per cycle. req.ready is high only while
// the sequencer is idle, so one transaction is in work at a time: the next
// request is taken only once the last result is in the response register.
// After reset the same sweep runs with req.ready low; configuration writes
// are taken at any time and cfg.ready stays high.
// The response sits in an output register: a new request is accepted while
// it waits, and the sequencer holds its result until rsp.ready frees the
// register.
module weighted_stratified_cross_tabulation import wsct_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    wsct_cfg_if.sink     cfg,
    wsct_req_if.sink     req,
    wsct_rsp_if.source   rsp
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [PROD_W-1:0] CELL_LIMIT = PROD_W'(MAX_CELLS);
    localparam logic [AW-1:0]     LAST_CELL  = AW'(MAX_CELLS - 1);

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_MUL_XY,
        S_MUL_SIZE,
        S_MUL_STRAT,
        S_MUL_YX,
        S_READ,
        S_UPDATE,
        S_EMIT
    } state_t;

    state_t                   state_reg;

    // Configuration registers
    logic [LEVEL_CFG_W-1:0]   x_levels_reg;
    logic [LEVEL_CFG_W-1:0]   y_levels_reg;
    logic [STRAT_CFG_W-1:0]   strata_reg;
    logic                     weighted_reg;

    // Captured request
    action_t                  act_reg;
    logic [LEVEL_W-1:0]       x_reg;
    logic [LEVEL_W-1:0]       y_reg;
    logic [STRATUM_W-1:0]     strat_reg;
    logic [WEIGHT_W-1:0]      weight_reg;
    logic                     bad_reg;

    // Sequencer datapath
    logic [MUL_A_W-1:0]       xy_reg;
    logic [PROD_W-1:0]        addr_reg;
    logic [AW-1:0]            sweep_reg;
    logic                     sweep_req_reg;
    count_t                   res_count_reg;
    status_t                  res_status_reg;

    // Response register
    logic                     rsp_valid_reg;
    count_t                   rsp_count_reg;
    status_t                  rsp_status_reg;

    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic [STRAT_CFG_W-1:0]   strata_eff;
    logic                     lvl_bad;
    logic [WEIGHT_W-1:0]      incr;
    logic [COUNT_W:0]         sum;
    logic                     sat;
    count_t                   new_count;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    count_t                   mem_wdata;
    count_t                   mem_rdata;
    logic                     rsp_free;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.count  = rsp_count_reg;
    assign rsp.status = rsp_status_reg;

    assign rsp_free   = !rsp_valid_reg || rsp.ready;
    assign strata_eff = (strata_reg == '0) ? STRAT_CFG_W'(1) : strata_reg;

    // Level and stratum range check on the incoming request
    assign lvl_bad = (x_levels_reg == '0) || (y_levels_reg == '0)
                  || ({1'b0, req.x_level} >= x_levels_reg)
                  || ({1'b0, req.y_level} >= y_levels_reg)
                  || ((strata_reg != '0)
                      && ((req.stratum == '0) || (req.stratum > strata_reg)));

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_XY:
            begin
                mul_a = MUL_A_W'(x_levels_reg);
                mul_b = y_levels_reg;
            end
            S_MUL_SIZE:
            begin
                mul_a = xy_reg;
                mul_b = MUL_B_W'(strata_eff);
            end
            S_MUL_STRAT:
            begin
                mul_a = xy_reg;
                mul_b = MUL_B_W'(strat_reg);
            end
            S_MUL_YX:
            begin
                mul_a = MUL_A_W'(x_levels_reg);
                mul_b = MUL_B_W'(y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Saturating cell update
    assign incr      = weighted_reg ? weight_reg : WEIGHT_W'(1);
    assign sum       = {1'b0, mem_rdata} + (COUNT_W + 1)'(incr);
    assign sat       = sum[COUNT_W];
    assign new_count = sat ? COUNT_MAX : sum[COUNT_W-1:0];

    // Memory write port: clearing sweep or accumulate write-back
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg[AW-1:0];
        mem_wdata = new_count;
        case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
            end
            S_UPDATE:
            begin
                mem_we = (act_reg == ACT_ACCUM);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    wsct_cell_mem #(
        .DEPTH (MAX_CELLS)
    ) u_cell_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    // Sequencer, configuration and response registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            x_levels_reg   <= LEVEL_CFG_W'(2);
            y_levels_reg   <= LEVEL_CFG_W'(1);
            strata_reg     <= '0;
            weighted_reg   <= 1'b0;
            act_reg        <= ACT_CLEAR;
            x_reg          <= '0;
            y_reg          <= '0;
            strat_reg      <= '0;
            weight_reg     <= '0;
            bad_reg        <= 1'b0;
            xy_reg         <= '0;
            addr_reg       <= '0;
            sweep_reg      <= '0;
            sweep_req_reg  <= 1'b0;
            res_count_reg  <= '0;
            res_status_reg <= ST_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_count_reg  <= '0;
            rsp_status_reg <= ST_OK;
        end
        else
        begin
            // Configuration writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.idx)
                    REG_X_LEVELS: x_levels_reg <= cfg.data;
                    REG_Y_LEVELS: y_levels_reg <= cfg.data;
                    REG_STRATA:   strata_reg   <= cfg.data[STRAT_CFG_W-1:0];
                    REG_WEIGHTED: weighted_reg <= cfg.data[0];
                    default:      ;
                endcase
            end

            // Response register drains on handshake; in S_EMIT it reloads instead
            if (rsp.valid && rsp.ready && (state_reg != S_EMIT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_SWEEP:
                begin
                    if (sweep_reg == LAST_CELL)
                    begin
                        sweep_reg <= '0;
                        if (sweep_req_reg)
                        begin
                            res_count_reg  <= '0;
                            res_status_reg <= ST_OK;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        act_reg    <= req.action;
                        x_reg      <= req.x_level;
                        y_reg      <= req.y_level;
                        weight_reg <= req.weight;
                        bad_reg    <= lvl_bad;
                        strat_reg  <= (strata_reg == '0) ? '0 : req.stratum - STRATUM_W'(1);
                        case (req.action)
                            ACT_CLEAR:
                            begin
                                sweep_reg     <= '0;
                                sweep_req_reg <= 1'b1;
                                state_reg     <= S_SWEEP;
                            end
                            ACT_ACCUM, ACT_READ:
                            begin
                                state_reg <= S_MUL_XY;
                            end
                            default:
                            begin
                                res_count_reg  <= '0;
                                res_status_reg <= ST_RANGE;
                                state_reg      <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_MUL_XY:
                begin
                    xy_reg    <= mul_p[MUL_A_W-1:0];
                    state_reg <= S_MUL_SIZE;
                end
                S_MUL_SIZE:
                begin
                    if (mul_p > CELL_LIMIT)
                    begin
                        bad_reg <= 1'b1;
                    end
                    state_reg <= S_MUL_STRAT;
                end
                S_MUL_STRAT:
                begin
                    addr_reg  <= mul_p + PROD_W'(x_reg);
                    state_reg <= S_MUL_YX;
                end
                S_MUL_YX:
                begin
                    addr_reg <= addr_reg + mul_p;
                    if (bad_reg)
                    begin
                        res_count_reg  <= '0;
                        res_status_reg <= ST_RANGE;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // read data lands in the memory output register
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (act_reg == ACT_ACCUM)
                    begin
                        res_count_reg  <= new_count;
                        res_status_reg <= sat ? ST_SAT : ST_OK;
                    end
                    else
                    begin
                        res_count_reg  <= mem_rdata;
                        res_status_reg <= ST_OK;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_count_reg  <= res_count_reg;
                        rsp_status_reg <= res_status_reg;
                        sweep_req_reg  <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/wsct_checker.sv
// Port-level assertions for the cross-tabulation engine, bound to the top level.
module wsct_checker import wsct_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [COUNT_W-1:0]  rsp_count,
    input logic [STATUS_W-1:0] rsp_status
);

    // A stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status))
        else $error("response changed while stalled");

    // One transaction in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // Range errors report a zero count
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_RANGE) |-> (rsp_count == '0))
        else $error("range error with nonzero count");

    // Saturation reports the ceiling value
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_SAT) |-> (rsp_count == COUNT_MAX))
        else $error("saturated count below ceiling");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_RANGE)
                      || (rsp_status == ST_SAT))
        else $error("undefined status code");

endmodule

bind weighted_stratified_cross_tabulation wsct_checker u_wsct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_count  (rsp.count),
    .rsp_status (rsp.status)
);

// File: dv/crosstab_tb_pkg.sv
// Request/response types and the cell-count scoreboard for the cross-tabulation testbench.
package crosstab_tb_pkg;
    import wsct_pkg::*;

    localparam int      TABLE_CELLS  = MAX_CELLS_DEFAULT;
    localparam action_t ACT_UNDEF    = 2'd3;

    typedef struct packed {
        action_t              action;
        logic [LEVEL_W-1:0]   x_level;
        logic [LEVEL_W-1:0]   y_level;
        logic [STRATUM_W-1:0] stratum;
        logic [WEIGHT_W-1:0]  weight;
    } request_t;

    typedef struct packed {
        count_t  count;
        status_t status;
    } outcome_t;

    // Mirror of the count memory and registers; queues the outcome of each request
    class crosstab_tracker;
        count_t                 cells [TABLE_CELLS];
        logic [LEVEL_CFG_W-1:0] x_levels;
        logic [LEVEL_CFG_W-1:0] y_levels;
        logic [STRAT_CFG_W-1:0] strata;
        logic                   weighted;
        outcome_t               awaited [$];
        int                     errors;

        function new();
            foreach (cells[i])
                cells[i] = '0;
            x_levels = 9'd2;
            y_levels = 9'd1;
            strata   = '0;
            weighted = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_X_LEVELS: x_levels = data[LEVEL_CFG_W-1:0];
                REG_Y_LEVELS: y_levels = data[LEVEL_CFG_W-1:0];
                REG_STRATA:   strata   = data[STRAT_CFG_W-1:0];
                REG_WEIGHTED: weighted = data[0];
                default: ;
            endcase
        endfunction

        // Memory index of a request, -1 when the layout, a level or the stratum is out of range
        function int cell_index(request_t r);
            longint lx;
            longint ly;
            longint lb;
            longint band;
            lx   = x_levels;
            ly   = y_levels;
            lb   = (strata != 0) ? strata : 1;
            band = 0;
            if (lx == 0 || ly == 0 || lx * ly * lb > TABLE_CELLS)
                return -1;
            if (r.x_level >= lx || r.y_level >= ly)
                return -1;
            // stratum only matters once strata are configured
            if (strata != 0)
            begin
                if (r.stratum == 0 || r.stratum > strata)
                    return -1;
                band = r.stratum - 1;
            end
            return int'(band * lx * ly + r.x_level + r.y_level * lx);
        endfunction

        // Called on each accepted request transaction
        function void note_request(request_t r);
            int         idx;
            logic [32:0] sum;
            outcome_t   o;
            o.count  = '0;
            o.status = ST_OK;
            case (r.action)
                ACT_CLEAR:
                begin
                    foreach (cells[i])
                        cells[i] = '0;
                end
                ACT_ACCUM:
                begin
                    idx = cell_index(r);
                    if (idx < 0)
                        o.status = ST_RANGE;
                    else
                    begin
                        sum = 33'(cells[idx]) + 33'(weighted ? r.weight : 16'd1);
                        if (sum > 33'(COUNT_MAX))
                        begin
                            sum      = 33'(COUNT_MAX);
                            o.status = ST_SAT;
                        end
                        cells[idx] = sum[COUNT_W-1:0];
                        o.count    = sum[COUNT_W-1:0];
                    end
                end
                ACT_READ:
                begin
                    idx = cell_index(r);
                    if (idx < 0)
                        o.status = ST_RANGE;
                    else
                        o.count = cells[idx];
                end
                default: o.status = ST_RANGE;
            endcase
            awaited.push_back(o);
        endfunction

        // Called on each accepted response transaction
        function void check_result(count_t count, status_t status);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: response with nothing outstanding: count %0d status %0d",
                         $time, count, status);
                return;
            end
            want = awaited.pop_front();
            if (count !== want.count)
            begin
                errors++;
                $display("%0t: count mismatch: expected %0d actual %0d",
                         $time, want.count, count);
            end
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

// File: dv/testbench.sv
// Top-level testbench: drives requests and register writes, checks every response.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsct_pkg::*;
    import crosstab_tb_pkg::*;

    localparam int PHASES          = 24;
    localparam int ITEMS_PER_PHASE = 33;

    typedef struct packed {
        logic [LEVEL_CFG_W-1:0] x;
        logic [LEVEL_CFG_W-1:0] y;
        logic [STRAT_CFG_W-1:0] s;
        logic                   w;
    } layout_t;

    logic clk;
    logic rst_n;

    wsct_cfg_if cfg ();
    wsct_req_if req ();
    wsct_rsp_if rsp ();

    weighted_stratified_cross_tabulation dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    crosstab_tracker book = new();
    int send_idle_pct = 20;
    int recv_idle_pct = 81;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    // Response side: random stalls, check each accepted transaction
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                book.check_result(rsp.count, rsp.status);
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic request_t make_req(action_t a, logic [LEVEL_W-1:0] x,
                                          logic [LEVEL_W-1:0] y,
                                          logic [STRATUM_W-1:0] s,
                                          logic [WEIGHT_W-1:0] w);
        request_t r;
        r.action  = a;
        r.x_level = x;
        r.y_level = y;
        r.stratum = s;
        r.weight  = w;
        return r;
    endfunction

    // Mostly in-range records for the current layout, some noise
    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 2)
            r.action = ACT_CLEAR;
        else if (pick < 5)
            r.action = ACT_UNDEF;
        else if (pick < 60)
            r.action = ACT_ACCUM;
        else
            r.action = ACT_READ;
        if (book.x_levels != 0 && book.x_levels <= 256 && $urandom_range(99) < 88)
            r.x_level = LEVEL_W'($urandom_range(book.x_levels - 1, 0));
        else
            r.x_level = LEVEL_W'($urandom);
        if (book.y_levels != 0 && book.y_levels <= 256 && $urandom_range(99) < 88)
            r.y_level = LEVEL_W'($urandom_range(book.y_levels - 1, 0));
        else
            r.y_level = LEVEL_W'($urandom);
        if (book.strata != 0 && $urandom_range(99) < 88)
            r.stratum = STRATUM_W'($urandom_range(book.strata, 1));
        else
            r.stratum = STRATUM_W'($urandom);
        pick = $urandom_range(9);
        if (pick == 0)
            r.weight = 16'hFFFF;
        else if (pick == 1)
            r.weight = 16'h0000;
        else
            r.weight = WEIGHT_W'($urandom);
        return r;
    endfunction

    // Every third phase takes a corner layout; the rest are small, within the table size, or raw
    function automatic layout_t random_layout(int phase);
        layout_t l;
        int      pick;
        int      ymax;
        int      smax;
        if (phase % 3 == 0)
        begin
            case (phase / 3)
                0:       l = '{9'd1,   9'd1,   5'd0,  1'b0};
                1:       l = '{9'd256, 9'd16,  5'd0,  1'b1};
                2:       l = '{9'd16,  9'd256, 5'd0,  1'b1};
                3:       l = '{9'd1,   9'd256, 5'd16, 1'b1};
                4:       l = '{9'd256, 9'd1,   5'd16, 1'b0};
                5:       l = '{9'd511, 9'd511, 5'd31, 1'b1};
                6:       l = '{9'd64,  9'd64,  5'd1,  1'b1};
                default: l = '{9'd0,   9'd3,   5'd2,  1'b1};
            endcase
            return l;
        end
        pick = $urandom_range(99);
        l.w  = 1'($urandom);
        if (pick < 55)
        begin
            l.x = 9'($urandom_range(16, 1));
            l.y = 9'($urandom_range(8, 1));
            l.s = 5'($urandom_range(4, 0));
        end
        else if (pick < 80)
        begin
            l.x  = 9'($urandom_range(256, 1));
            ymax = 4096 / l.x;
            ymax = (ymax > 256) ? 256 : ymax;
            l.y  = 9'($urandom_range(ymax, 1));
            smax = 4096 / (l.x * l.y);
            smax = (smax > 16) ? 16 : smax;
            l.s  = 5'($urandom_range(smax, 0));
        end
        else
        begin
            l.x = 9'($urandom);
            l.y = 9'($urandom);
            l.s = 5'($urandom);
        end
        return l;
    endfunction

    // One request transaction, with an occasional gap ahead of it
    task automatic put_request(request_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.action  <= r.action;
        req.x_level <= r.x_level;
        req.y_level <= r.y_level;
        req.stratum <= r.stratum;
        req.weight  <= r.weight;
        do
            @(posedge clk);
        while (!req.ready);
        book.note_request(r);
    endtask

    task automatic drain_responses();
        req.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.idx   <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        book.write_reg(idx, data);
    endtask

    // Register writes only once the engine has nothing in flight
    task automatic set_layout(layout_t l);
        drain_responses();
        write_reg(REG_X_LEVELS, l.x);
        write_reg(REG_Y_LEVELS, l.y);
        write_reg(REG_STRATA, {4'($urandom), l.s});
        write_reg(REG_WEIGHTED, {8'($urandom), l.w});
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        rst_n       <= 1'b0;
        req.valid   <= 1'b0;
        req.action  <= ACT_CLEAR;
        req.x_level <= '0;
        req.y_level <= '0;
        req.stratum <= '0;
        req.weight  <= '0;
        cfg.valid   <= 1'b0;
        cfg.idx     <= REG_X_LEVELS;
        cfg.data    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset layout: 2 x levels, 1 y level, no strata, unweighted
        put_request(make_req(ACT_READ,  8'd0, 8'd0, 5'd0,  16'd0));
        put_request(make_req(ACT_ACCUM, 8'd1, 8'd0, 5'd17, 16'hFFFF));
        put_request(make_req(ACT_ACCUM, 8'd2, 8'd0, 5'd0,  16'd1));
        put_request(make_req(ACT_ACCUM, 8'd0, 8'd1, 5'd0,  16'd1));
        put_request(make_req(ACT_UNDEF, 8'd0, 8'd0, 5'd0,  16'd0));
        put_request(make_req(ACT_READ,  8'd1, 8'd0, 5'd0,  16'd0));

        // Full-size two-way table, stratum ignored
        set_layout('{9'd256, 9'd16, 5'd0, 1'b1});
        put_request(make_req(ACT_ACCUM, 8'd255, 8'd15, 5'd0,  16'hFFFF));
        put_request(make_req(ACT_READ,  8'd255, 8'd15, 5'd31, 16'd0));

        // Full-size stratified table, strata out of range
        set_layout('{9'd16, 9'd16, 5'd16, 1'b1});
        put_request(make_req(ACT_ACCUM, 8'd15, 8'd15, 5'd16, 16'h8000));
        put_request(make_req(ACT_ACCUM, 8'd0,  8'd0,  5'd0,  16'd5));
        put_request(make_req(ACT_ACCUM, 8'd0,  8'd0,  5'd17, 16'd5));
        put_request(make_req(ACT_READ,  8'd15, 8'd15, 5'd16, 16'd0));

        // Layouts that are too large or empty
        set_layout('{9'd257, 9'd16, 5'd0, 1'b0});
        put_request(make_req(ACT_ACCUM, 8'd0, 8'd0, 5'd0, 16'd1));
        put_request(make_req(ACT_READ,  8'd0, 8'd0, 5'd0, 16'd0));
        set_layout('{9'd0, 9'd1, 5'd0, 1'b0});
        put_request(make_req(ACT_READ,  8'd0, 8'd0, 5'd0, 16'd0));
        set_layout('{9'd1, 9'd0, 5'd0, 1'b0});
        put_request(make_req(ACT_ACCUM, 8'd0, 8'd0, 5'd0, 16'd1));
        set_layout('{9'd511, 9'd511, 5'd31, 1'b1});
        put_request(make_req(ACT_ACCUM, 8'd255, 8'd255, 5'd31, 16'hFFFF));

        // Register writes leave the counts alone; clear wipes them
        set_layout('{9'd16, 9'd16, 5'd16, 1'b1});
        put_request(make_req(ACT_READ,  8'd15, 8'd15, 5'd16, 16'd0));
        put_request(make_req(ACT_CLEAR, 8'd0,  8'd0,  5'd0,  16'd0));
        put_request(make_req(ACT_READ,  8'd15, 8'd15, 5'd16, 16'd0));
        put_request(make_req(ACT_UNDEF, 8'hFF, 8'hFF, 5'h1F, 16'hFFFF));

        // Random phases; idle pattern changes at each third
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASES / 3)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 20;
            end
            else if (phase == 2 * PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_layout(random_layout(phase));
            repeat (ITEMS_PER_PHASE) put_request(random_request());
        end

        // Single-cell table, weighted then unweighted
        set_layout('{9'd1, 9'd1, 5'd0, 1'b1});
        put_request(make_req(ACT_CLEAR, 8'd0, 8'd0, 5'd0, 16'd0));
        put_request(make_req(ACT_ACCUM, 8'd0, 8'd0, 5'd0, 16'h7FFF));
        put_request(make_req(ACT_ACCUM, 8'd0, 8'd0, 5'd0, 16'd1));
        put_request(make_req(ACT_ACCUM, 8'd0, 8'd0, 5'd0, 16'd0));
        put_request(make_req(ACT_READ,  8'd0, 8'd0, 5'd0, 16'd0));
        set_layout('{9'd1, 9'd1, 5'd0, 1'b0});
        put_request(make_req(ACT_ACCUM, 8'd0, 8'd0, 5'd0, 16'd0));
        put_request(make_req(ACT_READ,  8'd0, 8'd0, 5'd0, 16'd0));

        drain_responses();
        repeat (20) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
